FILE: rtl/free_segment_fit_allocator_core_macros.svh
// ----------------------------------------------------------------------------
// Allocator assertion macros
// Shorthand for the concurrent checks at the end of the allocator top level.
// ----------------------------------------------------------------------------
`ifndef FREE_SEGMENT_FIT_ALLOCATOR_CORE_MACROS_SVH
`define FREE_SEGMENT_FIT_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define FSFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define FSFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// state in the cycle after a reset edge
`define FSFA_ASSERT_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/fsfa_pkg.sv
// ----------------------------------------------------------------------------
// Allocator package
// Shared constants, status codes and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package fsfa_pkg;

    localparam int MAX_SEGMENTS_DEF = 32;
    localparam int ADDR_BITS_DEF    = 24;
    localparam int FIELD_W          = 24;
    localparam int STATUS_W         = 2;

    localparam logic OP_ALLOC  = 1'b1;
    localparam logic POL_WORST = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // controller -> datapath (out_load goes to the output register)
    typedef struct packed {
        logic    capture;
        logic    wr_append;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    scan_clr;
        logic    rd;
        logic    cmp_en;
        logic    idx_inc;
        logic    idx_from_pick;
        logic    wr_shrink;
        logic    shift_wr;
        logic    res_load;
        logic    res_grant;
        t_status res_status;
        logic    out_load;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic op_alloc;
        logic full;
        logic cnt_zero;
        logic idx_last;
        logic found;
        logic exact;
        logic pick_last;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: rtl/fsfa_in_if.sv
// ----------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel carrying one request beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface fsfa_in_if
    import fsfa_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               op;
    logic               fit_policy;
    logic [FIELD_W-1:0] seg_start;
    logic [FIELD_W-1:0] seg_size;

    modport source (output valid, op, fit_policy, seg_start, seg_size, input ready);
    modport sink   (input valid, op, fit_policy, seg_start, seg_size, output ready);
endinterface

`default_nettype wire

FILE: rtl/fsfa_out_if.sv
// ----------------------------------------------------------------------------
// Allocator response channel
// Valid/ready channel carrying one response beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface fsfa_out_if
    import fsfa_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  granted_start;
    logic [FIELD_W-1:0]  granted_size;

    modport source (output valid, status, granted_start, granted_size, input ready);
    modport sink   (input valid, status, granted_start, granted_size, output ready);
endinterface

`default_nettype wire

FILE: rtl/fsfa_datapath.sv
// ----------------------------------------------------------------------------
// Allocator datapath
// Segment memory, fill count, scan index, best-candidate tracking, result.
// ----------------------------------------------------------------------------
`default_nettype none

module fsfa_datapath
    import fsfa_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_sts                  o_sts,
    input  wire logic                i_req_op,
    input  wire logic                i_req_policy,
    input  wire logic [FIELD_W-1:0]  i_req_start,
    input  wire logic [FIELD_W-1:0]  i_req_size,
    output logic [STATUS_W-1:0]      o_res_status,
    output logic [FIELD_W-1:0]       o_res_start,
    output logic [FIELD_W-1:0]       o_res_size
);

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int W  = ADDR_BITS;

    // segment memory, undefined until written
    logic [W-1:0] mem_start [MAX_SEGMENTS];
    logic [W-1:0] mem_size  [MAX_SEGMENTS];

    logic          r_op, r_policy;
    logic [W-1:0]  r_req_start, r_req_size;
    logic [CW-1:0] r_cnt;
    logic [IW-1:0] r_idx;
    logic [W-1:0]  r_rd_start, r_rd_size;
    logic [IW-1:0] r_rd_idx;
    logic          r_rd_vld;
    logic          r_found;
    logic [IW-1:0] r_pick;
    logic [W-1:0]  r_pick_start, r_pick_size;
    logic [STATUS_W-1:0] r_res_status;
    logic [FIELD_W-1:0]  r_res_start, r_res_size;

    logic          w_fits, w_better, w_take;
    logic          w_wr_en;
    logic [IW-1:0] w_wr_addr;
    logic [W-1:0]  w_wr_start, w_wr_size;
    logic [CW-1:0] w_cnt_m1;

    // candidate compare on the beat read last cycle
    always_comb begin
        w_fits   = (r_rd_size >= r_req_size);
        w_better = (r_policy == POL_WORST) ? (r_rd_size > r_pick_size)
                                           : (r_rd_size < r_pick_size);
        w_take   = i_cmd.cmp_en && r_rd_vld && w_fits && (!r_found || w_better);
    end

    // single write port
    always_comb begin
        w_wr_en    = 1'b0;
        w_wr_addr  = r_cnt[IW-1:0];
        w_wr_start = r_req_start;
        w_wr_size  = r_req_size;
        if (i_cmd.wr_append) begin
            w_wr_en = 1'b1;
        end else if (i_cmd.wr_shrink) begin
            w_wr_en    = 1'b1;
            w_wr_addr  = r_pick;
            w_wr_start = r_pick_start + r_req_size;
            w_wr_size  = r_pick_size - r_req_size;
        end else if (i_cmd.shift_wr && r_rd_vld) begin
            w_wr_en    = 1'b1;
            w_wr_addr  = r_rd_idx - IW'(1);
            w_wr_start = r_rd_start;
            w_wr_size  = r_rd_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem_start[w_wr_addr] <= w_wr_start;
            mem_size[w_wr_addr]  <= w_wr_size;
        end
        if (i_cmd.rd) begin
            r_rd_start <= mem_start[r_idx];
            r_rd_size  <= mem_size[r_idx];
            r_rd_idx   <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_rd_vld <= i_cmd.rd;
            if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_cnt <= w_cnt_m1;
            end
            if (i_cmd.scan_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_from_pick) begin
                r_idx <= r_pick + IW'(1);
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.scan_clr) begin
                r_found <= 1'b0;
            end else if (w_take) begin
                r_found <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op        <= i_req_op;
            r_policy    <= i_req_policy;
            r_req_start <= W'(i_req_start);
            r_req_size  <= W'(i_req_size);
        end
        if (w_take) begin
            r_pick       <= r_rd_idx;
            r_pick_start <= r_rd_start;
            r_pick_size  <= r_rd_size;
        end
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            r_res_start  <= i_cmd.res_grant ? FIELD_W'(r_pick_start) : '0;
            r_res_size   <= i_cmd.res_grant ? FIELD_W'(r_req_size) : '0;
        end
    end

    assign w_cnt_m1 = r_cnt - CW'(1);

    always_comb begin
        o_sts.op_alloc  = (r_op == OP_ALLOC);
        o_sts.full      = (r_cnt == CW'(MAX_SEGMENTS));
        o_sts.cnt_zero  = (r_cnt == '0);
        o_sts.idx_last  = (CW'(r_idx) == w_cnt_m1);
        o_sts.found     = r_found;
        o_sts.exact     = (r_pick_size == r_req_size);
        o_sts.pick_last = (CW'(r_pick) == w_cnt_m1);
    end

    assign o_res_status = r_res_status;
    assign o_res_start  = r_res_start;
    assign o_res_size   = r_res_size;

endmodule

`default_nettype wire

FILE: rtl/fsfa_ctrl.sv
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences append, scan, shrink/remove and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module fsfa_ctrl
    import fsfa_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_req_valid,
    output logic         o_req_ready,
    input  wire logic    i_slot_free,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SCAN_END,
        S_DECIDE,
        S_SHIFT,
        S_SHIFT_END,
        S_RESULT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!i_sts.op_alloc) begin
                    o_cmd.res_load = 1'b1;
                    if (i_sts.full) begin
                        o_cmd.res_status = ST_FULL;
                    end else begin
                        o_cmd.wr_append = 1'b1;
                        o_cmd.cnt_inc   = 1'b1;
                    end
                    n_state = S_RESULT;
                end else if (i_sts.cnt_zero) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_NOT_FOUND;
                    n_state          = S_RESULT;
                end else begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd      = 1'b1;
                o_cmd.cmp_en  = 1'b1;
                o_cmd.idx_inc = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                o_cmd.cmp_en = 1'b1;
                n_state      = S_DECIDE;
            end
            S_DECIDE: begin
                if (!i_sts.found) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_NOT_FOUND;
                    n_state          = S_RESULT;
                end else if (!i_sts.exact) begin
                    o_cmd.wr_shrink = 1'b1;
                    o_cmd.res_load  = 1'b1;
                    o_cmd.res_grant = 1'b1;
                    n_state         = S_RESULT;
                end else if (i_sts.pick_last) begin
                    o_cmd.cnt_dec   = 1'b1;
                    o_cmd.res_load  = 1'b1;
                    o_cmd.res_grant = 1'b1;
                    n_state         = S_RESULT;
                end else begin
                    o_cmd.idx_from_pick = 1'b1;
                    n_state             = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.rd       = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                o_cmd.shift_wr = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_SHIFT_END;
                end
            end
            S_SHIFT_END: begin
                o_cmd.shift_wr  = 1'b1;
                o_cmd.cnt_dec   = 1'b1;
                o_cmd.res_load  = 1'b1;
                o_cmd.res_grant = 1'b1;
                n_state         = S_RESULT;
            end
            S_RESULT: begin
                if (i_slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/free_segment_fit_allocator_core.sv
// ----------------------------------------------------------------------------
// Free segment fit allocator
// Ordered table of free segments with tail append and best/worst fit grant.
// Request channel i_req: op selects append (seg_start, seg_size) or allocate
// (seg_size = request, fit_policy = best or worst). One response beat on
// o_rsp per request: status, granted_start, granted_size.
// One request is in flight at a time; the table lives in a single-port-write,
// registered-read memory, so an allocate scans one entry a cycle.
// An append, or an allocate on an empty table, is answered from dispatch;
// any other allocate scans the table, then decides, and when an exact fit
// removes a middle entry the later entries are copied up one a cycle. The
// request channel is ready again as soon as the response is loaded into
// the output register.
// No table clear at reset.
// Reset empties the table (fill count to zero) and drops any pending response.
// The response sits in an output register: a stalled receiver holds it there
// while the next request is already taken and worked on; that one then waits
// for the slot to free up.
// ----------------------------------------------------------------------------
`default_nettype none
`include "free_segment_fit_allocator_core_macros.svh"

module free_segment_fit_allocator_core
    import fsfa_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fsfa_in_if.sink    i_req,
    fsfa_out_if.source o_rsp
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_slot_free;

    logic [STATUS_W-1:0] w_res_status;
    logic [FIELD_W-1:0]  w_res_start, w_res_size;

    // response output register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [FIELD_W-1:0]  r_out_start, r_out_size;

    assign w_slot_free = !r_out_valid || o_rsp.ready;

    fsfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_slot_free (w_slot_free),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    fsfa_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_req_op     (i_req.op),
        .i_req_policy (i_req.fit_policy),
        .i_req_start  (i_req.seg_start),
        .i_req_size   (i_req.seg_size),
        .o_res_status (w_res_status),
        .o_res_start  (w_res_start),
        .o_res_size   (w_res_size)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            r_out_status <= w_res_status;
            r_out_start  <= w_res_start;
            r_out_size   <= w_res_size;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.granted_start = r_out_start;
    assign o_rsp.granted_size  = r_out_size;

    // checks
    `FSFA_ASSERT_NOW(a_no_overwrite, w_cmd.out_load, w_slot_free, "response overwritten")
    `FSFA_ASSERT_NEXT(a_one_in_flight, i_req.valid && i_req.ready, !i_req.ready, "second beat taken")
    `FSFA_ASSERT_RST(a_rst_clean, !r_out_valid && i_req.ready, "reset left state behind")

endmodule

`default_nettype wire

FILE: sim/tb_free_segment_fit_allocator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Free segment fit allocator testbench
// Directed table of requests, then randomised fill / churn / drain / noise
// phases. A shadow free list predicts each response the table does not give, and
// every response beat is checked field by field against the oldest expected one.
// ----------------------------------------------------------------------------

module tb_free_segment_fit_allocator_core;
    import fsfa_pkg::*;

    localparam int   MAX_SEG    = MAX_SEGMENTS_DEF;
    localparam logic OP_APPEND  = ~OP_ALLOC;
    localparam logic POL_BEST   = ~POL_WORST;
    localparam int   N_RANDOM   = 1250;
    localparam int   IDLE_LIMIT = 2000;  // cycles without any beat on either side
    localparam int   DRAIN_WAIT = 80;    // worst allocate latency plus margin

    // one response beat as predicted
    typedef struct packed {
        t_status            status;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] len;
    } t_grant;

    // directed row; fixed_exp marks rows whose response is typed in here
    typedef struct packed {
        logic               op;
        logic               pol;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] len;
        logic               fixed_exp;
        t_grant             want;
    } t_dir_row;

    // Walk-through of the special cases
    t_dir_row dir_tab [25] = '{
        // empty table: nothing can fit, even a zero-size request
        '{OP_ALLOC,  POL_BEST,  24'h000000, 24'h000000, 1'b1, '{ST_NOT_FOUND, 24'h0, 24'h0}},
        '{OP_ALLOC,  POL_WORST, 24'hFFFFFF, 24'hFFFFFF, 1'b1, '{ST_NOT_FOUND, 24'h0, 24'h0}},
        // appends answer ok with zero grant, policy bit has no effect
        '{OP_APPEND, POL_WORST, 24'hFFFFFF, 24'hFFFFFF, 1'b1, '{ST_OK, 24'h0, 24'h0}},
        '{OP_APPEND, POL_BEST,  24'h000000, 24'h000000, 1'b1, '{ST_OK, 24'h0, 24'h0}},
        '{OP_APPEND, POL_BEST,  24'h000100, 24'h000010, 1'b1, '{ST_OK, 24'h0, 24'h0}},
        '{OP_APPEND, POL_WORST, 24'h000200, 24'h000010, 1'b1, '{ST_OK, 24'h0, 24'h0}},
        // zero request, best fit: takes the size-0 entry (exact, middle removal)
        '{OP_ALLOC,  POL_BEST,  24'hAAAAAA, 24'h000000, 1'b1, '{ST_OK, 24'h000000, 24'h0}},
        // tie on size 0x10: earliest wins, exact, later entry moves up
        '{OP_ALLOC,  POL_BEST,  24'h555555, 24'h000010, 1'b1,
          '{ST_OK, 24'h000100, 24'h000010}},
        // worst fit on the top segment: start wraps past the address space
        '{OP_ALLOC,  POL_WORST, 24'h000000, 24'h000010, 1'b1,
          '{ST_OK, 24'hFFFFFF, 24'h000010}},
        // zero request on a larger segment: entry left as it was
        '{OP_ALLOC,  POL_BEST,  24'h000000, 24'h000000, 1'b1, '{ST_OK, 24'h000200, 24'h0}},
        '{OP_ALLOC,  POL_BEST,  24'h000000, 24'hFFFFFF, 1'b1, '{ST_NOT_FOUND, 24'h0, 24'h0}},
        '{OP_ALLOC,  POL_WORST, 24'h000000, 24'hFFFFEF, 1'b1,
          '{ST_OK, 24'h00000F, 24'hFFFFEF}},
        // shrink then exact on the last entry, table empty again
        '{OP_ALLOC,  POL_BEST,  24'h000000, 24'h000008, 1'b0, '{ST_OK, 24'h0, 24'h0}},
        '{OP_ALLOC,  POL_BEST,  24'h000000, 24'h000008, 1'b0, '{ST_OK, 24'h0, 24'h0}},
        // all-zero table: worst fit with zero request takes the earliest
        '{OP_APPEND, POL_BEST,  24'h123456, 24'h000000, 1'b1, '{ST_OK, 24'h0, 24'h0}},
        '{OP_APPEND, POL_WORST, 24'h654321, 24'h000000, 1'b1, '{ST_OK, 24'h0, 24'h0}},
        '{OP_APPEND, POL_BEST,  24'h00FF00, 24'h000000, 1'b1, '{ST_OK, 24'h0, 24'h0}},
        '{OP_ALLOC,  POL_WORST, 24'h000000, 24'h000000, 1'b1, '{ST_OK, 24'h123456, 24'h0}},
        '{OP_ALLOC,  POL_WORST, 24'h000000, 24'h000001, 1'b1, '{ST_NOT_FOUND, 24'h0, 24'h0}},
        // mixed sizes: exact on last, zero grant from largest, exact on first, exact on last
        '{OP_APPEND, POL_BEST,  24'h000800, 24'h000040, 1'b0, '{ST_OK, 24'h0, 24'h0}},
        '{OP_APPEND, POL_BEST,  24'h000900, 24'h000020, 1'b0, '{ST_OK, 24'h0, 24'h0}},
        '{OP_ALLOC,  POL_BEST,  24'h000000, 24'h000020, 1'b0, '{ST_OK, 24'h0, 24'h0}},
        '{OP_ALLOC,  POL_WORST, 24'h000000, 24'h000000, 1'b0, '{ST_OK, 24'h0, 24'h0}},
        '{OP_ALLOC,  POL_BEST,  24'h000000, 24'h000000, 1'b0, '{ST_OK, 24'h0, 24'h0}},
        '{OP_ALLOC,  POL_WORST, 24'h000000, 24'h000040, 1'b0, '{ST_OK, 24'h0, 24'h0}}
    };

    logic i_clk;
    logic i_rst_n;

    fsfa_in_if  req_if ();
    fsfa_out_if rsp_if ();

    free_segment_fit_allocator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // shadow free list
    logic [FIELD_W-1:0] free_start [MAX_SEG];
    logic [FIELD_W-1:0] free_len   [MAX_SEG];
    int                 free_cnt;

    t_grant grant_q [$];   // responses still owed by the block
    int     n_err = 0;
    int     n_rand;
    int     idle_cycles = 0;
    bit     rst_done;
    bit     calm;          // set for phases with no idling on either side

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Apply one request to the shadow list and return the response it earns.
    function automatic t_grant predict_grant(input logic op, input logic pol,
                                             input logic [FIELD_W-1:0] start,
                                             input logic [FIELD_W-1:0] len);
        t_grant             r;
        int                 pick;
        logic [FIELD_W-1:0] pick_len;
        logic               hit;
        r        = '{ST_OK, '0, '0};
        pick     = 0;
        pick_len = '0;
        hit      = 1'b0;
        if (op != OP_ALLOC) begin
            if (free_cnt >= MAX_SEG) begin
                r.status = ST_FULL;
            end else begin
                free_start[free_cnt] = start;
                free_len[free_cnt]   = len;
                free_cnt++;
            end
            return r;
        end
        // strict compare keeps the earliest entry on a tie
        for (int i = 0; i < free_cnt; i++) begin
            if (free_len[i] >= len &&
                (!hit || (pol == POL_WORST ? free_len[i] > pick_len
                                           : free_len[i] < pick_len))) begin
                hit      = 1'b1;
                pick     = i;
                pick_len = free_len[i];
            end
        end
        if (!hit) begin
            r.status = ST_NOT_FOUND;
            return r;
        end
        r.start = free_start[pick];
        r.len   = len;
        if (pick_len > len) begin
            free_start[pick] = free_start[pick] + len;   // wraps at the field width
            free_len[pick]   = pick_len - len;
        end else begin
            for (int i = pick; i + 1 < free_cnt; i++) begin
                free_start[i] = free_start[i + 1];
                free_len[i]   = free_len[i + 1];
            end
            free_cnt--;
        end
        return r;
    endfunction

    // Mostly small sizes so that ties and exact fits are common.
    function automatic logic [FIELD_W-1:0] rand_len();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return FIELD_W'($urandom);
            2:       return '1;
            default: return FIELD_W'($urandom_range(1, 64));
        endcase
    endfunction

    // Request size for an allocate: often an exact or near fit of a live entry.
    function automatic logic [FIELD_W-1:0] rand_request();
        logic [FIELD_W-1:0] v;
        if (free_cnt == 0 || $urandom_range(0, 3) == 0)
            return rand_len();
        v = free_len[$urandom_range(0, free_cnt - 1)];
        case ($urandom_range(0, 5))
            0:       return v + FIELD_W'(1);             // just too big for this one
            1:       return (v > FIELD_W'(4)) ? v - FIELD_W'($urandom_range(1, 4)) : v;
            2:       return v >> 1;
            default: return v;
        endcase
    endfunction

    // Offer one request beat; predict its response once it is taken.
    task automatic send_req(input logic op, input logic pol,
                            input logic [FIELD_W-1:0] start,
                            input logic [FIELD_W-1:0] len,
                            input logic fixed_exp, input t_grant want);
        int     gap;
        t_grant got;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.op         <= op;
        req_if.fit_policy <= pol;
        req_if.seg_start  <= start;
        req_if.seg_size   <= len;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
        got = predict_grant(op, pol, start, len);
        grant_q.push_back(fixed_exp ? want : got);
    endtask

    task automatic send_rand(input logic op, input logic [FIELD_W-1:0] len);
        send_req(op, logic'($urandom_range(0, 1)), FIELD_W'($urandom), len, 1'b0,
                 '{ST_OK, '0, '0});
        n_rand++;
    endtask

    // hold requests back until every response is home
    task automatic drain_all();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (grant_q.size() != 0) @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        int k;
        int guard;
        req_if.valid      <= 1'b0;
        req_if.op         <= OP_APPEND;
        req_if.fit_policy <= POL_BEST;
        req_if.seg_start  <= '0;
        req_if.seg_size   <= '0;
        i_rst_n           <= 1'b0;
        free_cnt = 0;
        n_rand   = 0;
        calm     = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done = 1'b1;

        foreach (dir_tab[i])
            send_req(dir_tab[i].op, dir_tab[i].pol, dir_tab[i].start, dir_tab[i].len,
                     dir_tab[i].fixed_exp, dir_tab[i].want);

        // first random phase is always a fill to full, from a quiet block
        k = 0;
        while (n_rand < N_RANDOM) begin
            if (k == 0 || $urandom_range(0, 2) == 0)
                drain_all();
            calm = ($urandom_range(0, 3) == 0);
            case (k == 0 ? 0 : $urandom_range(0, 4))
                0: begin
                    // fill, then knock on the full table a few times
                    while (free_cnt < MAX_SEG)
                        send_rand(OP_APPEND, rand_len());
                    repeat ($urandom_range(1, 3))
                        send_rand(OP_APPEND, rand_len());
                end
                1, 2: begin
                    // churn at whatever fill level the table has
                    repeat ($urandom_range(20, 60)) begin
                        if ($urandom_range(0, 1) == 0)
                            send_rand(OP_APPEND, rand_len());
                        else
                            send_rand(OP_ALLOC, rand_request());
                    end
                end
                3: begin
                    // drain, mostly by exact fits
                    guard = 0;
                    while (free_cnt > 0 && guard < 100) begin
                        send_rand(OP_ALLOC, rand_request());
                        guard++;
                    end
                end
                default: begin
                    // noise: every field at full range
                    repeat (8)
                        send_rand(logic'($urandom_range(0, 1)), FIELD_W'($urandom));
                end
            endcase
            k++;
        end
        calm = 1'b0;

        req_if.valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_err == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Response side: random stall per beat, then check against the oldest
    // outstanding prediction.
    initial begin
        int     stall;
        t_grant e;
        rsp_if.ready <= 1'b0;
        wait (rst_done);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge i_clk);
            while (rsp_if.valid !== 1'b1) @(posedge i_clk);
            if (grant_q.size() == 0) begin
                n_err++;
                $display("%0t: unexpected response beat: status %0d start %h size %h",
                         $time, rsp_if.status, rsp_if.granted_start, rsp_if.granted_size);
            end else begin
                e = grant_q.pop_front();
                if (rsp_if.status !== e.status) begin
                    n_err++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, e.status, rsp_if.status);
                end
                if (rsp_if.granted_start !== e.start) begin
                    n_err++;
                    $display("%0t: granted_start expected %h actual %h",
                             $time, e.start, rsp_if.granted_start);
                end
                if (rsp_if.granted_size !== e.len) begin
                    n_err++;
                    $display("%0t: granted_size expected %h actual %h",
                             $time, e.len, rsp_if.granted_size);
                end
            end
        end
    end

    // Watchdog: too long without a beat on either channel means a hang.
    always @(posedge i_clk) begin
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
            (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d responses outstanding",
                     $time, IDLE_LIMIT, grant_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

FILE: free_segment_fit_allocator_core.f
+incdir+rtl
rtl/fsfa_pkg.sv
rtl/fsfa_in_if.sv
rtl/fsfa_out_if.sv
rtl/fsfa_datapath.sv
rtl/fsfa_ctrl.sv
rtl/free_segment_fit_allocator_core.sv
sim/tb_free_segment_fit_allocator_core.sv
